### src/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, field widths, character codes, command codes and the
// types shared between the console control logic and its screen memory.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = ROWS * COLUMNS;
    localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W       = $clog2(CELLS);

    localparam int CMD_W  = 3;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;

    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

    localparam logic [CMD_W-1:0] CMD_PUT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

    typedef logic [ADDR_W-1:0] addr_t;

    // One screen cell: attribute in the high byte, character in the low byte.
    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [CHAR_W-1:0] ch;
    } cell_t;

    // Access request from the control logic to the screen memory.
    typedef struct packed {
        logic  we;
        addr_t waddr;
        cell_t wdata;
        logic  re;
        addr_t raddr;
    } mem_req_t;

endpackage

### src/tcw_screen_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console screen memory
// One write port and one read port with registered read data, holding one
// character and attribute cell per screen position in row-major order.
// ----------------------------------------------------------------------------
module tcw_screen_ram (
    input  logic             aclk,
    input  tcw_pkg::mem_req_t req,
    output tcw_pkg::cell_t   rdata
);

    tcw_pkg::cell_t mem [tcw_pkg::CELLS];
    tcw_pkg::cell_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// Character and attribute screen store with a cursor, driven by a command
// stream and returning the cursor and an optional cell read per command.
// ----------------------------------------------------------------------------
// Every command returns exactly one result transaction. Put character
// (unless it scrolls), erase, cursor moves and unused codes load their result
// straight from idle; read cell passes through ST_READ first, because the
// screen memory registers its read data. Clear screen walks the whole store
// at one cell per cycle. A newline or a wrap on the last row scrolls: the
// store is copied up one row at one cell per cycle and the last row is
// blanked. The single write port of the screen memory sets this pace.
// After reset the store is cleared to spaces with attribute 15, during which
// s_tready stays low; the attribute register can be written at any time
// while the block is idle.
module text_console_writer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,    // text_attr

    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] cmd, [10:3] char_code, [15:11] read_row, [22:16] read_col
    input  logic [23:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] cursor_row, [11:5] cursor_col, [19:12] cell_char, [27:20] cell_attr
    output logic [31:0] m_tdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_SCROLL = 3'd2;
    localparam logic [2:0] ST_BLANK  = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;

    localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
    localparam logic [tcw_pkg::COL_W-1:0] FULL_COL = tcw_pkg::COL_W'(tcw_pkg::COLUMNS);
    localparam logic [tcw_pkg::COL_W-1:0] EDGE_COL = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);

    function automatic tcw_pkg::addr_t cell_addr(input logic [tcw_pkg::ROW_W-1:0] r,
                                                 input logic [tcw_pkg::COL_W-1:0] c);
        cell_addr = tcw_pkg::ADDR_W'(r) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
                    + tcw_pkg::ADDR_W'(c);
    endfunction

    logic [2:0]                   state_reg, state_next;
    tcw_pkg::addr_t               cnt_reg, cnt_next;
    logic [tcw_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [tcw_pkg::COL_W-1:0]    col_reg, col_next;
    logic [tcw_pkg::ATTR_W-1:0]   attr_reg;
    logic                         init_reg, init_next;
    logic                         pend_put_reg, pend_put_next;
    logic [tcw_pkg::CHAR_W-1:0]   pend_ch_reg, pend_ch_next;
    logic                         rd_ok_reg, rd_ok_next;
    logic                         m_valid_reg, m_valid_next;
    logic [31:0]                  m_data_reg, m_data_next;

    logic [tcw_pkg::CMD_W-1:0]    in_cmd;
    logic [tcw_pkg::CHAR_W-1:0]   in_char;
    logic [tcw_pkg::ROW_W-1:0]    in_row;
    logic [tcw_pkg::COL_W-1:0]    in_col;
    logic                         s_fire;
    logic                         load_out;
    logic [tcw_pkg::CHAR_W-1:0]   out_ch;
    logic [tcw_pkg::ATTR_W-1:0]   out_at;
    logic [tcw_pkg::COL_W-1:0]    adv_col;

    tcw_pkg::mem_req_t            req;
    tcw_pkg::cell_t               rdata;

    tcw_screen_ram u_ram (
        .aclk  (aclk),
        .req   (req),
        .rdata (rdata)
    );

    assign in_cmd  = s_tdata[2:0];
    assign in_char = s_tdata[10:3];
    assign in_row  = s_tdata[15:11];
    assign in_col  = s_tdata[22:16];

    assign cfg_ready = 1'b1;
    // A new command enters in idle once the previous result is gone or leaving now.
    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Cursor column after storing a character at column zero of a new line.
    assign adv_col = (in_char == tcw_pkg::CH_BACKSPACE) ? '0 : tcw_pkg::COL_W'(1);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        init_next     = init_reg;
        pend_put_next = pend_put_reg;
        pend_ch_next  = pend_ch_reg;
        rd_ok_next    = rd_ok_reg;
        load_out      = 1'b0;
        out_ch        = '0;
        out_at        = '0;
        req           = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (in_cmd)
                        tcw_pkg::CMD_PUT: begin
                            if (in_char == tcw_pkg::CH_NEWLINE) begin
                                col_next = '0;
                                if (row_reg != LAST_ROW) begin
                                    row_next = row_reg + tcw_pkg::ROW_W'(1);
                                    load_out = 1'b1;
                                end else begin
                                    pend_put_next = 1'b0;
                                    cnt_next      = '0;
                                    state_next    = ST_SCROLL;
                                end
                            end else if (col_reg >= FULL_COL) begin
                                col_next = adv_col;
                                if (row_reg != LAST_ROW) begin
                                    row_next    = row_reg + tcw_pkg::ROW_W'(1);
                                    req.we      = 1'b1;
                                    req.waddr   = cell_addr(row_reg + tcw_pkg::ROW_W'(1), '0);
                                    req.wdata   = '{attr: attr_reg, ch: in_char};
                                    load_out    = 1'b1;
                                end else begin
                                    // The character lands on column zero of the
                                    // blanked last row after the scroll.
                                    pend_put_next = 1'b1;
                                    pend_ch_next  = in_char;
                                    cnt_next      = '0;
                                    state_next    = ST_SCROLL;
                                end
                            end else begin
                                req.we    = 1'b1;
                                req.waddr = cell_addr(row_reg, col_reg);
                                req.wdata = '{attr: attr_reg, ch: in_char};
                                if (in_char == tcw_pkg::CH_BACKSPACE) begin
                                    if (col_reg != '0) begin
                                        col_next = col_reg - tcw_pkg::COL_W'(1);
                                    end
                                end else begin
                                    col_next = col_reg + tcw_pkg::COL_W'(1);
                                end
                                load_out = 1'b1;
                            end
                        end
                        tcw_pkg::CMD_ERASE: begin
                            if (col_reg != '0) begin
                                col_next  = col_reg - tcw_pkg::COL_W'(1);
                                req.we    = 1'b1;
                                req.waddr = cell_addr(row_reg, col_reg - tcw_pkg::COL_W'(1));
                                req.wdata = '{attr: attr_reg, ch: tcw_pkg::CH_SPACE};
                            end
                            load_out = 1'b1;
                        end
                        tcw_pkg::CMD_LEFT: begin
                            if (col_reg != '0) begin
                                col_next = col_reg - tcw_pkg::COL_W'(1);
                            end
                            load_out = 1'b1;
                        end
                        tcw_pkg::CMD_RIGHT: begin
                            if (col_reg < EDGE_COL) begin
                                col_next = col_reg + tcw_pkg::COL_W'(1);
                            end
                            load_out = 1'b1;
                        end
                        tcw_pkg::CMD_CLEAR: begin
                            cnt_next   = '0;
                            state_next = ST_FILL;
                        end
                        tcw_pkg::CMD_READ: begin
                            rd_ok_next = (in_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
                                      && (in_col < FULL_COL);
                            req.re     = 1'b1;
                            req.raddr  = cell_addr(in_row, in_col);
                            state_next = ST_READ;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (rd_ok_reg) begin
                    out_ch = rdata.ch;
                    out_at = rdata.attr;
                end
                load_out   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCROLL: begin
                // Read one row ahead, write the previous read in the next cycle.
                if (cnt_reg != tcw_pkg::ADDR_W'(tcw_pkg::SCROLL_CELLS)) begin
                    req.re    = 1'b1;
                    req.raddr = cnt_reg + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
                end
                if (cnt_reg != '0) begin
                    req.we    = 1'b1;
                    req.waddr = cnt_reg - tcw_pkg::ADDR_W'(1);
                    req.wdata = rdata;
                end
                if (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::SCROLL_CELLS)) begin
                    cnt_next   = '0;
                    state_next = ST_BLANK;
                end else begin
                    cnt_next = cnt_reg + tcw_pkg::ADDR_W'(1);
                end
            end
            ST_BLANK: begin
                req.we    = 1'b1;
                req.waddr = tcw_pkg::ADDR_W'(tcw_pkg::SCROLL_CELLS) + cnt_reg;
                if (cnt_reg == '0 && pend_put_reg) begin
                    req.wdata = '{attr: attr_reg, ch: pend_ch_reg};
                end else begin
                    req.wdata = '{attr: attr_reg, ch: tcw_pkg::CH_SPACE};
                end
                if (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS - 1)) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + tcw_pkg::ADDR_W'(1);
                end
            end
            ST_FILL: begin
                req.we    = 1'b1;
                req.waddr = cnt_reg;
                req.wdata = '{attr: (init_reg ? tcw_pkg::ATTR_RESET : attr_reg),
                              ch: tcw_pkg::CH_SPACE};
                if (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1)) begin
                    // The clearing pass after reset returns no result.
                    load_out   = !init_reg;
                    init_next  = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + tcw_pkg::ADDR_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_data_next  = {4'b0000, out_at, out_ch, col_next, row_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_FILL;
            cnt_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            attr_reg    <= tcw_pkg::ATTR_RESET;
            init_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            init_reg    <= init_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_put_reg <= pend_put_next;
        pend_ch_reg  <= pend_ch_next;
        rd_ok_reg    <= rd_ok_next;
        m_data_reg   <= m_data_next;
    end

endmodule

### tb/text_console_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Streams console commands into the writer and checks every returned cursor
// and cell read against a screen image kept in the testbench. The attribute
// register is changed between phases, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam int PHASE_ITEMS    = 250;
    localparam int SETTLE_CYCLES  = 2100;   // longer than a clear or a scroll
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 300;

    // One command, packed the same way as s_tdata.
    typedef struct packed {
        logic [COL_W-1:0]  rc;
        logic [ROW_W-1:0]  rr;
        logic [CHAR_W-1:0] ch;
        logic [CMD_W-1:0]  cmd;
    } console_cmd_t;

    // One result, packed the same way as the low 28 bits of m_tdata.
    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } console_view_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = 24'h0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    text_console_writer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Screen image and cursor as the testbench expects them.
    cell_t             screen_img [CELLS];
    logic [ROW_W-1:0]  crs_row;
    logic [COL_W-1:0]  crs_col;
    logic [ATTR_W-1:0] attr_now;

    console_cmd_t  cmd_backlog [$];
    console_view_t expected_views [$];

    int issued = 0;
    int tx_count = 0;
    int rx_count = 0;
    int errors = 0;
    int tx_wait = 0;
    int rx_wait = 0;
    int rx_hold = 0;
    int rx_holds = 0;
    int quiet = 0;
    bit tx_bursty = 1'b0;
    bit rx_bursty = 1'b0;

    function automatic void blank_line(int r);
        for (int c = 0; c < COLUMNS; c++)
            screen_img[r * COLUMNS + c] = cell_t'({attr_now, CH_SPACE});
    endfunction

    function automatic void line_feed();
        crs_col = '0;
        if (crs_row < ROWS - 1) begin
            crs_row++;
        end else begin
            for (int i = 0; i < SCROLL_CELLS; i++)
                screen_img[i] = screen_img[i + COLUMNS];
            blank_line(ROWS - 1);
        end
    endfunction

    // Applies one command to the screen image and returns the result it gives.
    function automatic console_view_t console_step(console_cmd_t c);
        console_view_t v;
        v = '0;
        case (c.cmd)
            CMD_PUT: begin
                if (c.ch == CH_NEWLINE) begin
                    line_feed();
                end else begin
                    if (crs_col >= COLUMNS)
                        line_feed();
                    screen_img[int'(crs_row) * COLUMNS + int'(crs_col)] =
                        cell_t'({attr_now, c.ch});
                    if (c.ch == CH_BACKSPACE) begin
                        if (crs_col > 0)
                            crs_col--;
                    end else begin
                        crs_col++;
                    end
                end
            end
            CMD_ERASE: begin
                if (crs_col > 0) begin
                    crs_col--;
                    screen_img[int'(crs_row) * COLUMNS + int'(crs_col)] =
                        cell_t'({attr_now, CH_SPACE});
                end
            end
            CMD_LEFT: begin
                if (crs_col > 0)
                    crs_col--;
            end
            CMD_RIGHT: begin
                if (crs_col < COLUMNS - 1)
                    crs_col++;
            end
            CMD_CLEAR: begin
                for (int r = 0; r < ROWS; r++)
                    blank_line(r);
            end
            CMD_READ: begin
                if (c.rr < ROWS && c.rc < COLUMNS) begin
                    v.ch   = screen_img[int'(c.rr) * COLUMNS + int'(c.rc)].ch;
                    v.attr = screen_img[int'(c.rr) * COLUMNS + int'(c.rc)].attr;
                end
            end
            default: ;
        endcase
        v.row = crs_row;
        v.col = crs_col;
        return v;
    endfunction

    function automatic void check_view(logic [31:0] d);
        console_view_t got;
        console_view_t want;
        got = console_view_t'(d[27:0]);
        if (expected_views.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result %0d: row %0d col %0d char %02h attr %02h",
                         rx_count, got.row, got.col, got.ch, got.attr);
            return;
        end
        want = expected_views.pop_front();
        if (got.row !== want.row || got.col !== want.col ||
            got.ch !== want.ch || got.attr !== want.attr) begin
            errors++;
            if (errors <= 10) begin
                $display("result %0d: expected row %0d col %0d char %02h attr %02h,",
                         rx_count, want.row, want.col, want.ch, want.attr);
                $display("    got row %0d col %0d char %02h attr %02h",
                         got.row, got.col, got.ch, got.attr);
            end
        end
    endfunction

    // Sender: takes commands from the backlog and predicts each accepted one.
    always @(posedge aclk) begin : tx_side
        console_cmd_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_views.push_back(console_step(console_cmd_t'(s_tdata[22:0])));
                tx_count <= tx_count + 1;
                if (tx_count % 50 == 49)
                    tx_bursty <= ($urandom_range(0, 3) == 0);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_wait > 0) begin
                    s_tvalid <= 1'b0;
                    tx_wait  <= tx_wait - 1;
                end else if (cmd_backlog.size() > 0) begin
                    c = cmd_backlog.pop_front();
                    s_tdata  <= {1'b0, c};
                    s_tvalid <= 1'b1;
                    tx_wait  <= tx_bursty ? 0 : $urandom_range(0, 8);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result and stalls at random. At most twice it
    // holds off for a long stretch while commands are still waiting, so the
    // block fills up and has to stall its input.
    always @(posedge aclk) begin : rx_side
        int gap;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
            rx_hold  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_view(m_tdata);
                rx_count <= rx_count + 1;
                if (rx_count % 64 == 63)
                    rx_bursty <= ($urandom_range(0, 2) == 0);
                if (rx_holds < 2 && rx_count > 300 * (rx_holds + 1) &&
                    cmd_backlog.size() > 20) begin
                    rx_holds <= rx_holds + 1;
                    rx_hold  <= HOLD_CYCLES;
                    m_tready <= 1'b0;
                end else begin
                    gap = rx_bursty ? 0 : $urandom_range(0, 8);
                    rx_wait  <= gap;
                    m_tready <= (gap == 0);
                end
            end else if (rx_hold > 0) begin
                rx_hold  <= rx_hold - 1;
                m_tready <= (rx_hold == 1);
            end else if (rx_wait > 0) begin
                rx_wait  <= rx_wait - 1;
                m_tready <= (rx_wait == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("** text_console_writer: FAILED **");
                $finish;
            end
        end
    end

    task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
        console_cmd_t c;
        c = '{rc: rc, rr: rr, ch: ch, cmd: cmd};
        cmd_backlog.push_back(c);
        issued++;
    endtask

    // Random filler for fields that a command ignores.
    function automatic logic [CHAR_W-1:0] rnd_char();
        return CHAR_W'($urandom);
    endfunction

    function automatic logic [ROW_W-1:0] rnd_row();
        return ROW_W'($urandom);
    endfunction

    function automatic logic [COL_W-1:0] rnd_col();
        return COL_W'($urandom);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(0, 15) == 0)
            return rnd_char();
        return CHAR_W'($urandom_range(8'h20, 8'h7E));
    endfunction

    // A read that often hits the bottom rows, where scrolling shows up,
    // and now and then falls outside the screen.
    task automatic add_read();
        logic [ROW_W-1:0] rr;
        logic [COL_W-1:0] rc;
        case ($urandom_range(0, 7))
            0: begin
                rr = ROW_W'($urandom_range(ROWS, 31));
                rc = rnd_col();
            end
            1: begin
                rr = rnd_row();
                rc = COL_W'($urandom_range(COLUMNS, 127));
            end
            2, 3, 4: begin
                rr = ROW_W'($urandom_range(ROWS - 2, ROWS - 1));
                rc = COL_W'($urandom_range(0, COLUMNS - 1));
            end
            default: begin
                rr = ROW_W'($urandom_range(0, ROWS - 1));
                rc = COL_W'($urandom_range(0, COLUMNS - 1));
            end
        endcase
        add_cmd(CMD_READ, rnd_char(), rr, rc);
    endtask

    task automatic add_random_stretch();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            n = $urandom_range(1, 90);
            repeat (n) add_cmd(CMD_PUT, pick_char(), rnd_row(), rnd_col());
        end else if (kind < 40) begin
            // Fill one line exactly, then probe the full-line cursor.
            add_cmd(CMD_PUT, CH_NEWLINE, rnd_row(), rnd_col());
            repeat (COLUMNS) add_cmd(CMD_PUT, CHAR_W'($urandom_range(8'h21, 8'h7E)),
                                     rnd_row(), rnd_col());
            add_cmd(CMD_W'($urandom_range(CMD_PUT, CMD_RIGHT)), pick_char(),
                    rnd_row(), rnd_col());
            add_read();
        end else if (kind < 52) begin
            n = $urandom_range(1, 6);
            repeat (n) add_cmd(CMD_PUT, CH_NEWLINE, rnd_row(), rnd_col());
        end else if (kind < 64) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat (COLUMNS + 5) add_cmd(CMD_RIGHT, rnd_char(), rnd_row(), rnd_col());
            end else begin
                n = $urandom_range(1, 20);
                repeat (n) add_cmd(CMD_W'($urandom_range(CMD_ERASE, CMD_RIGHT)), rnd_char(),
                                   rnd_row(), rnd_col());
            end
        end else if (kind < 80) begin
            n = $urandom_range(1, 8);
            repeat (n) add_read();
        end else if (kind < 84) begin
            add_cmd(CMD_CLEAR, rnd_char(), rnd_row(), rnd_col());
        end else begin
            n = $urandom_range(1, 10);
            repeat (n) add_cmd(CMD_W'($urandom), rnd_char(), rnd_row(), rnd_col());
        end
    endtask

    task automatic wait_drained();
        while (!(tx_count == issued && rx_count >= tx_count))
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_attr(input logic [ATTR_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        attr_now = value;
    endtask

    task automatic run_phase();
        int first;
        first = issued;
        while (issued - first < PHASE_ITEMS)
            add_random_stretch();
        wait_drained();
    endtask

    initial begin
        crs_row  = '0;
        crs_col  = '0;
        attr_now = ATTR_RESET;
        for (int r = 0; r < ROWS; r++)
            blank_line(r);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening, at the reset attribute.
        add_cmd(CMD_READ, 8'h00, 5'd0, 7'd0);
        add_cmd(CMD_ERASE, 8'hFF, 5'd31, 7'd127);    // erase at column zero
        add_cmd(CMD_LEFT, 8'h00, 5'd0, 7'd0);
        add_cmd(CMD_PUT, 8'h41, 5'd0, 7'd0);
        add_cmd(CMD_PUT, 8'hFF, 5'd0, 7'd0);
        add_cmd(CMD_PUT, 8'h00, 5'd0, 7'd0);
        add_cmd(CMD_PUT, CH_BACKSPACE, 5'd0, 7'd0);
        add_cmd(CMD_RIGHT, 8'h00, 5'd0, 7'd0);
        add_cmd(CMD_RIGHT, 8'h00, 5'd0, 7'd0);
        add_cmd(CMD_ERASE, 8'h00, 5'd0, 7'd0);
        add_cmd(CMD_READ, 8'h00, 5'd0, 7'd3);
        add_cmd(CMD_READ, 8'h00, 5'd0, 7'd1);
        add_cmd(CMD_PUT, CH_NEWLINE, 5'd0, 7'd0);
        add_cmd(CMD_PUT, CH_BACKSPACE, 5'd0, 7'd0); // backspace at column zero
        add_cmd(CMD_READ, 8'h00, 5'd1, 7'd0);
        add_cmd(CMD_SPARE_LO, 8'hFF, 5'd31, 7'd127);
        add_cmd(CMD_SPARE_HI, 8'h00, 5'd0, 7'd0);
        add_cmd(CMD_READ, 8'h00, 5'd24, 7'd79);
        add_cmd(CMD_READ, 8'h00, 5'd25, 7'd0);
        add_cmd(CMD_READ, 8'h00, 5'd0, 7'd80);
        add_cmd(CMD_READ, 8'hFF, 5'd31, 7'd127);
        add_cmd(CMD_CLEAR, 8'h00, 5'd0, 7'd0);
        add_cmd(CMD_READ, 8'h00, 5'd1, 7'd0);
        run_phase();

        write_attr(8'h00);
        run_phase();
        write_attr(8'hFF);
        run_phase();
        write_attr(ATTR_W'($urandom));
        run_phase();
        write_attr(ATTR_W'($urandom));
        run_phase();

        if (expected_views.size() != 0) begin
            errors += expected_views.size();
            $display("%0d expected results never arrived", expected_views.size());
        end
        if (errors == 0) begin
            $display("** text_console_writer: PASSED **");
        end else begin
            $display("** text_console_writer: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
src/tcw_pkg.sv
src/tcw_screen_ram.sv
src/text_console_writer.sv
tb/text_console_writer_tb.sv
